// ----- sv/vertex_transform_4x4_core_macros.svh -----
// Assertion macros shared by the vertex transform core.
`ifndef VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define VT4_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("vt4 implication check failed");

// Condition that must hold at every clock edge outside reset.
`define VT4_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("vt4 invariant check failed");

`endif

// ----- sv/vt4_pkg.sv -----
package vt4_pkg;

    // Widths of the ports, fixed by the interface.
    localparam int IO_BITS       = 32;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 4;
    localparam int HALF_BITS     = 32;

    // Matrix geometry.
    localparam int N_COMP      = 4;
    localparam int NUM_REGS    = 8;
    localparam int MAT_ENTRIES = 16;
    localparam int REG_SEL_BITS = 3;

    // Pipeline depth from the output of the input register to the result.
    localparam int ROW_STAGES = 4;

    // Per-row result flags handed to the top level.
    typedef struct packed {
        logic valid;
        logic sat;
    } t_row_status;

endpackage

// ----- sv/vertex_transform_4x4_core.sv -----
// Vertex transform core: 4x4 matrix times 4-vector in signed fixed point.
// The vector taken at the start edge passes the input register and then the product, pair, sum
// and result registers of each row before the result strobe rises.
// Throughput: one vector per cycle; busy stays low and the pipeline never stalls.
// Reset (synchronous, active low) loads the identity matrix and clears all valid bits.
module vertex_transform_4x4_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vt4_pkg::IO_BITS-1:0]       i_in_x,
    input  logic [vt4_pkg::IO_BITS-1:0]       i_in_y,
    input  logic [vt4_pkg::IO_BITS-1:0]       i_in_z,
    input  logic [vt4_pkg::IO_BITS-1:0]       i_in_w,
    output logic                              o_out_valid,
    output logic [vt4_pkg::IO_BITS-1:0]       o_out_x,
    output logic [vt4_pkg::IO_BITS-1:0]       o_out_y,
    output logic [vt4_pkg::IO_BITS-1:0]       o_out_z,
    output logic [vt4_pkg::IO_BITS-1:0]       o_out_w,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vt4_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [vt4_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import vt4_pkg::*;
    `include "vertex_transform_4x4_core_macros.svh"

    logic [MAT_ENTRIES-1:0][WORD_BITS-1:0] w_entries;
    logic [N_COMP-1:0][WORD_BITS-1:0]      r_vec;
    logic                                  r_in_valid;
    logic                                  w_accept;
    logic [N_COMP-1:0][WORD_BITS-1:0]      w_res;
    t_row_status [N_COMP-1:0]              w_status;
    logic [N_COMP-1:0]                     w_row_valid;
    logic [N_COMP-1:0]                     w_row_sat;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Matrix configuration storage.
    vt4_matrix_regs #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_entries   (w_entries)
    );

    // Input register; only the low word bits of each component count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vec[0] <= i_in_x[WORD_BITS-1:0];
            r_vec[1] <= i_in_y[WORD_BITS-1:0];
            r_vec[2] <= i_in_z[WORD_BITS-1:0];
            r_vec[3] <= i_in_w[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    // One dot product pipeline per output row; column-major entry 4*c+r.
    for (genvar r = 0; r < N_COMP; r++) begin : g_row
        logic [N_COMP-1:0][WORD_BITS-1:0] w_coef;
        for (genvar c = 0; c < N_COMP; c++) begin : g_col
            assign w_coef[c] = w_entries[N_COMP*c + r];
        end

        vt4_row_unit #(
            .FRAC_BITS (FRAC_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_row (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (r_in_valid),
            .i_coef   (w_coef),
            .i_vec    (r_vec),
            .o_res    (w_res[r]),
            .o_status (w_status[r])
        );

        assign w_row_valid[r] = w_status[r].valid;
        assign w_row_sat[r]   = w_status[r].sat;
    end

    // Results are sign-extended from the word width to the port width.
    assign o_out_valid = w_row_valid[0];
    assign o_out_x     = IO_BITS'($signed(w_res[0]));
    assign o_out_y     = IO_BITS'($signed(w_res[1]));
    assign o_out_z     = IO_BITS'($signed(w_res[2]));
    assign o_out_w     = IO_BITS'($signed(w_res[3]));
    assign o_saturated = |w_row_sat;

    // Every accepted vector produces its result a fixed number of cycles later.
    `VT4_ASSERT_IMPLY(a_fixed_latency, w_accept, ##(ROW_STAGES + 1) o_out_valid)
    // The four row pipelines advance in lock step.
    `VT4_ASSERT_ALWAYS(a_rows_aligned, (w_row_valid == '0) || (w_row_valid == '1))

endmodule

// ----- sv/vt4_matrix_regs.sv -----
module vt4_matrix_regs #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [vt4_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [vt4_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic [vt4_pkg::MAT_ENTRIES-1:0][WORD_BITS-1:0] o_entries
);
    import vt4_pkg::*;

    // Fixed point one; truncates to zero when it does not fit the word.
    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(64'd1 << FRAC_BITS);

    // Identity matrix: entries 15, 10, 5 and 0 hold one, the rest are zero.
    localparam logic [MAT_ENTRIES-1:0][WORD_BITS-1:0] RESET_ENTRIES = {
        ONE, {(N_COMP*WORD_BITS){1'b0}},
        ONE, {(N_COMP*WORD_BITS){1'b0}},
        ONE, {(N_COMP*WORD_BITS){1'b0}},
        ONE
    };

    logic [MAT_ENTRIES-1:0][WORD_BITS-1:0] r_entries;
    logic [MAT_ENTRIES-1:0][WORD_BITS-1:0] n_entries;
    logic [REG_SEL_BITS-1:0]               w_sel;
    logic                                  w_wr;

    // Writes with an index past the last register are dropped.
    assign w_sel = i_cfg_index[REG_SEL_BITS-1:0];
    assign w_wr  = i_cfg_valid && (i_cfg_index < CFG_IDX_BITS'(NUM_REGS));

    // Each register carries two entries; only the low word bits of a half are kept.
    always_comb begin
        n_entries = r_entries;
        if (w_wr) begin
            n_entries[{w_sel, 1'b0}] = i_cfg_data[WORD_BITS-1:0];
            n_entries[{w_sel, 1'b1}] = i_cfg_data[HALF_BITS+WORD_BITS-1:HALF_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= RESET_ENTRIES;
        end else begin
            r_entries <= n_entries;
        end
    end

    assign o_entries = r_entries;

endmodule

// ----- sv/vt4_row_unit.sv -----
module vt4_row_unit #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [vt4_pkg::N_COMP-1:0][WORD_BITS-1:0] i_coef,
    input  logic [vt4_pkg::N_COMP-1:0][WORD_BITS-1:0] i_vec,
    output logic [WORD_BITS-1:0]                      o_res,
    output vt4_pkg::t_row_status                      o_status
);
    import vt4_pkg::*;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int PAIR_BITS = PROD_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int TOP_BITS  = SUM_BITS - WORD_BITS + 1;

    logic [N_COMP-1:0][PROD_BITS-1:0] r_prod;
    logic [1:0][PAIR_BITS-1:0]        r_pair;
    logic signed [SUM_BITS-1:0]       r_sum;
    logic [WORD_BITS-1:0]             r_res;
    logic                             r_sat;
    logic [2:0]                       r_valid;
    logic                             r_out_valid;

    logic signed [SUM_BITS-1:0]       w_shift;
    logic [TOP_BITS-1:0]              w_top;
    logic                             w_sat;
    logic [WORD_BITS-1:0]             n_res;

    // Stage one: four exact signed products.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < N_COMP; c++) begin
            r_prod[c] <= PROD_BITS'($signed(i_coef[c]) * $signed(i_vec[c]));
        end
    end

    // Stage two: pairwise sums.
    always_ff @(posedge i_clk) begin
        r_pair[0] <= PAIR_BITS'($signed(r_prod[0])) + PAIR_BITS'($signed(r_prod[1]));
        r_pair[1] <= PAIR_BITS'($signed(r_prod[2])) + PAIR_BITS'($signed(r_prod[3]));
    end

    // Stage three: full precision dot product.
    always_ff @(posedge i_clk) begin
        r_sum <= SUM_BITS'($signed(r_pair[0])) + SUM_BITS'($signed(r_pair[1]));
    end

    // Stage four: arithmetic shift floors, then clip to the signed word range.
    always_comb begin
        w_shift = r_sum >>> FRAC_BITS;
        w_top   = w_shift[SUM_BITS-1:WORD_BITS-1];
        w_sat   = !((w_top == '0) || (w_top == '1));
        if (!w_sat) begin
            n_res = w_shift[WORD_BITS-1:0];
        end else if (w_shift[SUM_BITS-1]) begin
            n_res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            n_res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sat <= w_sat;
    end

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= {r_valid[1:0], i_valid};
            r_out_valid <= r_valid[2];
        end
    end

    assign o_res          = r_res;
    assign o_status.valid = r_out_valid;
    assign o_status.sat   = r_sat;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import vt4_pkg::*;

    localparam int FRAC = 16;
    localparam int WORD = 32;
    localparam int CLK_HALF_NS = 5;
    localparam int RESET_CYCLES = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int DRAIN_CYCLES = ROW_STAGES + 4;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int IDX_SPACE = 1 << CFG_IDX_BITS;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_NEG_ONE_LSB = 32'hFFFF_FFFF;

    localparam logic signed [67:0] ROW_MAX = (68'sd1 <<< (WORD - 1)) - 68'sd1;
    localparam logic signed [67:0] ROW_MIN = -(68'sd1 <<< (WORD - 1));

    // Kinds of matrix loaded for a phase of the run.
    typedef enum int {
        MAT_IDENTITY,
        MAT_ZERO,
        MAT_ALL_MAX,
        MAT_ALL_MIN,
        MAT_SMALL,
        MAT_MIXED,
        MAT_FULL
    } matrix_kind_e;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        sat;
    } vertex_result_t;

    // Keeps a shadow of the matrix and the transformed vertices still due.
    class vertex_scoreboard;
        logic signed [31:0] matrix [MAT_ENTRIES];
        vertex_result_t expected_vertices [$];
        int errors;

        function new();
            errors = 0;
            // Reset loads the identity: diagonal entries are 0, 5, 10 and 15.
            for (int k = 0; k < MAT_ENTRIES; k++) begin
                matrix[k] = (k % 5 == 0) ? $signed(Q_ONE) : 32'sd0;
            end
        endfunction

        // Only the low WORD bits of a half count, as a two's complement number.
        static function logic signed [31:0] to_word(logic [31:0] raw);
            return $signed(raw << (32 - WORD)) >>> (32 - WORD);
        endfunction

        function void write_register(int idx, logic [63:0] data);
            // Writes to indexes past the last register are dropped.
            if (idx < NUM_REGS) begin
                matrix[2 * idx]     = to_word(data[31:0]);
                matrix[2 * idx + 1] = to_word(data[63:32]);
            end
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        // Full-precision dot product per row, floor shift, then saturation.
        function void note_vector(logic [31:0] x, logic [31:0] y,
                                  logic [31:0] z, logic [31:0] w);
            logic signed [31:0] comp [N_COMP];
            logic signed [63:0] prod;
            logic signed [67:0] acc;
            logic signed [67:0] row_val;
            logic [31:0]        rows [N_COMP];
            vertex_result_t     vert;
            comp[0] = to_word(x);
            comp[1] = to_word(y);
            comp[2] = to_word(z);
            comp[3] = to_word(w);
            vert.sat = 1'b0;
            for (int r = 0; r < N_COMP; r++) begin
                acc = '0;
                for (int c = 0; c < N_COMP; c++) begin
                    prod = matrix[4 * c + r] * comp[c];
                    acc  = acc + prod;
                end
                row_val = acc >>> FRAC;
                if (row_val > ROW_MAX) begin
                    row_val  = ROW_MAX;
                    vert.sat = 1'b1;
                end else if (row_val < ROW_MIN) begin
                    row_val  = ROW_MIN;
                    vert.sat = 1'b1;
                end
                rows[r] = row_val[31:0];
            end
            vert.x = rows[0];
            vert.y = rows[1];
            vert.z = rows[2];
            vert.w = rows[3];
            expected_vertices.push_back(vert);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [31:0] w, logic sat);
            vertex_result_t vert;
            if (expected_vertices.size() == 0) begin
                report_mismatch("result word with no vector outstanding");
                return;
            end
            vert = expected_vertices.pop_front();
            if (x !== vert.x)
                report_mismatch($sformatf("out_x got %h expected %h", x, vert.x));
            if (y !== vert.y)
                report_mismatch($sformatf("out_y got %h expected %h", y, vert.y));
            if (z !== vert.z)
                report_mismatch($sformatf("out_z got %h expected %h", z, vert.z));
            if (w !== vert.w)
                report_mismatch($sformatf("out_w got %h expected %h", w, vert.w));
            if (sat !== vert.sat)
                report_mismatch($sformatf("saturated got %b expected %b", sat, vert.sat));
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [IO_BITS-1:0]       i_in_x;
    logic [IO_BITS-1:0]       i_in_y;
    logic [IO_BITS-1:0]       i_in_z;
    logic [IO_BITS-1:0]       i_in_w;
    logic                     o_out_valid;
    logic [IO_BITS-1:0]       o_out_x;
    logic [IO_BITS-1:0]       o_out_y;
    logic [IO_BITS-1:0]       o_out_z;
    logic [IO_BITS-1:0]       o_out_w;
    logic                     o_saturated;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    vertex_scoreboard sb = new();

    vertex_transform_4x4_core #(
        .FRAC_BITS (FRAC),
        .WORD_BITS (WORD)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .i_in_w      (i_in_w),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Every strobed result word is checked against the oldest expected vertex.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid) begin
            sb.check_result(o_out_x, o_out_y, o_out_z, o_out_w, o_saturated);
        end
    end

    // Writes one matrix register once the configuration channel takes it.
    // Valid stays high so the next write can follow at once; the caller drops it.
    task automatic write_matrix_reg(int idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_BITS-1:0];
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
    endtask

    // Presents one vector and holds it until the core takes it; start stays high.
    task automatic send_vector(logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] w);
        start  <= 1'b1;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        i_in_w <= w;
        do @(posedge i_clk); while (busy);
        sb.note_vector(x, y, z, w);
    endtask

    task automatic idle_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Called only right after a vector was taken, so a result is always still pending on entry.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] signed_magnitude(logic [31:0] mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Mostly modest coordinates, with some full-range and boundary values.
    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return Q_NEG_ONE_LSB;
                    3: return Q_MAX;
                    default: return Q_MIN;
                endcase
            end
            default: return signed_magnitude($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    function automatic logic [31:0] matrix_entry(matrix_kind_e kind, int k);
        case (kind)
            MAT_IDENTITY: return (k % 5 == 0) ? Q_ONE : 32'h0;
            MAT_ZERO:     return 32'h0;
            MAT_ALL_MAX:  return Q_MAX;
            MAT_ALL_MIN:  return Q_MIN;
            MAT_SMALL:    return signed_magnitude($urandom_range(0, 32'h0004_0000));
            MAT_MIXED: begin
                if ($urandom_range(0, 3) == 0)
                    return $urandom();
                return signed_magnitude($urandom_range(0, 32'h0004_0000));
            end
            default:      return $urandom();
        endcase
    endfunction

    // Loads all eight registers, then pokes one index past the last register.
    task automatic load_matrix(matrix_kind_e kind);
        for (int idx = 0; idx < NUM_REGS; idx++) begin
            write_matrix_reg(idx, {matrix_entry(kind, 2 * idx + 1),
                                   matrix_entry(kind, 2 * idx)});
        end
        write_matrix_reg($urandom_range(NUM_REGS, IDX_SPACE - 1), {$urandom(), $urandom()});
        i_cfg_valid <= 1'b0;
    endtask

    // Main stimulus.
    initial begin
        matrix_kind_e kind;
        bit           quiet;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_in_x      <= '0;
        i_in_y      <= '0;
        i_in_z      <= '0;
        i_in_w      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity from reset: extremes pass through unchanged.
        send_vector(32'h0, 32'h0, 32'h0, 32'h0);
        send_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_vector(Q_ONE, -Q_ONE, 32'h1, Q_NEG_ONE_LSB);
        send_vector(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        drain_results();

        // Largest positive entries: overflow both ways and floor rounding.
        load_matrix(MAT_ALL_MAX);
        send_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_vector(32'h1, 32'h0, 32'h0, 32'h0);
        send_vector(Q_NEG_ONE_LSB, 32'h0, 32'h0, 32'h0);
        send_vector(32'h0, 32'h0, 32'h0, 32'h0);
        drain_results();

        // Most negative entries.
        load_matrix(MAT_ALL_MIN);
        send_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vector(Q_ONE, 32'h0, 32'h0, 32'h0);
        drain_results();

        // Zero matrix, then an explicit identity load.
        load_matrix(MAT_ZERO);
        send_vector(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        drain_results();
        load_matrix(MAT_IDENTITY);
        send_vector(Q_ONE, 32'h0002_0000, 32'h0003_8000, Q_NEG_ONE_LSB);
        drain_results();

        // Random phases; the last one runs back to back with no idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind  = (p == 0) ? MAT_SMALL : matrix_kind_e'($urandom_range(0, 6));
            quiet = (p == RANDOM_PHASES - 1);
            load_matrix(kind);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle_sender($urandom_range(1, 10));
                send_vector(random_component(), random_component(),
                            random_component(), random_component());
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch("vertices still outstanding at end of run");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #TIMEOUT_NS;
        $display("Verification failed");
        $finish;
    end

endmodule
